// ===== rtl/ebpt_pkg.sv =====
// shared types, codes and decode functions of the 8-bit pwm timer
package ebpt_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_EDGE  = 3'd3,
    REQ_GATE  = 3'd4
  } req_e;

  // register map
  typedef enum logic [2:0] {
    REG_CTRL_A = 3'd0,
    REG_CTRL_B = 3'd1,
    REG_COUNT  = 3'd2,
    REG_OCR_A  = 3'd3,
    REG_OCR_B  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    WV_NORMAL   = 3'd0,
    WV_PC       = 3'd1,
    WV_CTC      = 3'd2,
    WV_FAST     = 3'd3,
    WV_RESERVED = 3'd4
  } wave_e;

  typedef enum logic [2:0] {
    OC_NONE     = 3'd0,
    OC_TOGGLE   = 3'd1,
    OC_CLEAR    = 3'd2,
    OC_SET      = 3'd3,
    OC_RESERVED = 3'd4
  } act_e;

  // value selectors for top, overflow point and buffer update point
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_00   = 2'd1,
    SEL_FF   = 2'd2,
    SEL_OCRA = 2'd3
  } sel_e;

  // raw waveform codes {wgm2, wgm1, wgm0}
  localparam logic [2:0] WGM_NORMAL    = 3'd0;
  localparam logic [2:0] WGM_PC_FF     = 3'd1;
  localparam logic [2:0] WGM_CTC       = 3'd2;
  localparam logic [2:0] WGM_FAST_FF   = 3'd3;
  localparam logic [2:0] WGM_RSV_LO    = 3'd4;
  localparam logic [2:0] WGM_PC_OCRA   = 3'd5;
  localparam logic [2:0] WGM_RSV_HI    = 3'd6;
  localparam logic [2:0] WGM_FAST_OCRA = 3'd7;

  // compare output mode field
  localparam logic [1:0] COM_OFF    = 2'd0;
  localparam logic [1:0] COM_TOGGLE = 2'd1;
  localparam logic [1:0] COM_CLEAR  = 2'd2;
  localparam logic [1:0] COM_SET    = 2'd3;

  // clock select codes
  localparam logic [2:0] CS_STOP     = 3'd0;
  localparam logic [2:0] CS_DIV1     = 3'd1;
  localparam logic [2:0] CS_DIV8     = 3'd2;
  localparam logic [2:0] CS_DIV64    = 3'd3;
  localparam logic [2:0] CS_DIV256   = 3'd4;
  localparam logic [2:0] CS_DIV1024  = 3'd5;
  localparam logic [2:0] CS_EXT_FALL = 3'd6;
  localparam logic [2:0] CS_EXT_RISE = 3'd7;

  localparam logic [7:0] CTRL_A_MASK = 8'hF3;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_FULL   = 8'hFF;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    act_e on_match;
    act_e on_top;
  } act_pair_t;

  typedef struct packed {
    logic [7:0] ctrl_a;
    logic [3:0] ctrl_b;
    logic [7:0] count;
    logic [7:0] ocra_act;
    logic [7:0] ocrb_act;
    logic [7:0] ocra_buf;
    logic [7:0] ocrb_buf;
    logic       dir_up;
    logic       blocked;
    logic [2:0] gate;      // bit0 sleep, bit1 power, bit2 sync hold
    logic [1:0] pins;      // bit0 pin a, bit1 pin b
  } state_t;

  localparam state_t STATE_RESET = '{
    ctrl_a:   8'h00,
    ctrl_b:   4'h0,
    count:    8'h00,
    ocra_act: 8'h00,
    ocrb_act: 8'h00,
    ocra_buf: 8'h00,
    ocrb_buf: 8'h00,
    dir_up:   1'b1,
    blocked:  1'b0,
    gate:     3'b000,
    pins:     2'b00
  };

  typedef struct packed {
    logic [2:0] req;
    logic [2:0] idx;
    logic [7:0] data;
    logic [4:0] taps;
    logic       rising;
    logic       sleep;
    logic       power;
    logic       sync;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] count_now;
    logic       pin_a_level;
    logic       pin_b_level;
    logic       pin_a_owned;
    logic       pin_b_owned;
    logic       ovf;
    logic       match_a;
    logic       match_b;
    logic       reserved;
  } result_t;

  function automatic wave_e wave_of(input logic [2:0] code);
    wave_e w;
    case (code) inside
      WGM_NORMAL:                 w = WV_NORMAL;
      WGM_PC_FF, WGM_PC_OCRA:     w = WV_PC;
      WGM_CTC:                    w = WV_CTC;
      WGM_FAST_FF, WGM_FAST_OCRA: w = WV_FAST;
      default:                    w = WV_RESERVED;
    endcase
    return w;
  endfunction

  function automatic sel_e top_of(input logic [2:0] code);
    sel_e s;
    case (code) inside
      WGM_NORMAL, WGM_PC_FF, WGM_FAST_FF:  s = SEL_FF;
      WGM_CTC, WGM_PC_OCRA, WGM_FAST_OCRA: s = SEL_OCRA;
      default:                             s = SEL_NONE;
    endcase
    return s;
  endfunction

  function automatic sel_e ovf_of(input logic [2:0] code);
    sel_e s;
    case (code) inside
      WGM_NORMAL, WGM_CTC, WGM_FAST_FF: s = SEL_FF;
      WGM_PC_FF, WGM_PC_OCRA:           s = SEL_00;
      WGM_FAST_OCRA:                    s = SEL_OCRA;
      default:                          s = SEL_NONE;
    endcase
    return s;
  endfunction

  function automatic sel_e upd_of(input logic [2:0] code);
    sel_e s;
    case (code) inside
      WGM_PC_FF:                  s = SEL_FF;
      WGM_FAST_FF, WGM_FAST_OCRA: s = SEL_00;
      WGM_PC_OCRA:                s = SEL_OCRA;
      default:                    s = SEL_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] sel_value(input sel_e sel, input logic [7:0] ocra);
    logic [7:0] v;
    case (sel)
      SEL_00:   v = BYTE_ZERO;
      SEL_OCRA: v = ocra;
      default:  v = BYTE_FULL;
    endcase
    return v;
  endfunction

  // compare output mode decode, with the pwm special cases
  function automatic act_pair_t actions(input logic [1:0] com, input logic is_b,
                                        input wave_e wave, input logic wgm2);
    act_pair_t p;
    case (com)
      COM_TOGGLE: p.on_match = OC_TOGGLE;
      COM_CLEAR:  p.on_match = OC_CLEAR;
      COM_SET:    p.on_match = OC_SET;
      default:    p.on_match = OC_NONE;
    endcase
    p.on_top = OC_NONE;
    if (wave == WV_PC || wave == WV_FAST) begin
      if (p.on_match == OC_TOGGLE) begin
        if (is_b) begin
          p.on_match = OC_RESERVED;
        end else if (!wgm2) begin
          p.on_match = OC_NONE;
        end
      end else if (p.on_match == OC_CLEAR && wave == WV_FAST) begin
        p.on_top = OC_SET;
      end else if (p.on_match == OC_SET && wave == WV_FAST) begin
        p.on_top = OC_CLEAR;
      end
    end
    return p;
  endfunction

  function automatic logic apply_act(input logic level, input act_e act, input logic up);
    logic l;
    l = level;
    case (act)
      OC_TOGGLE: l = ~level;
      OC_SET:    l = up;
      OC_CLEAR:  l = ~up;
      default:   l = level;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/ebpt_step.sv =====
// next state and result of one request, combinational
module ebpt_step
  import ebpt_pkg::*;
(
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [2:0] code, new_code, fin_code;
  logic [2:0] cs;
  wave_e      wave, new_wave, fin_wave;
  logic       tap_hit, tick_en, dbuf, dir, lvl_a, lvl_b;
  logic [7:0] top;
  act_pair_t  pa, pb, na, nb, fa, fb;
  sel_e       upd;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    code     = {state_i.ctrl_b[3], state_i.ctrl_a[1:0]};
    wave     = wave_of(code);
    cs       = state_i.ctrl_b[2:0];
    dbuf     = (upd_of(code) != SEL_NONE);
    new_code = code;
    new_wave = wave;
    na       = '0;
    nb       = '0;
    tick_en  = 1'b0;
    dir      = state_i.dir_up;
    lvl_a    = state_i.pins[0];
    lvl_b    = state_i.pins[1];

    case (cs)
      CS_DIV1:    tap_hit = item_i.taps[0];
      CS_DIV8:    tap_hit = item_i.taps[1];
      CS_DIV64:   tap_hit = item_i.taps[2];
      CS_DIV256:  tap_hit = item_i.taps[3];
      CS_DIV1024: tap_hit = item_i.taps[4];
      default:    tap_hit = 1'b0;
    endcase

    case (item_i.req)
      REQ_WRITE: begin
        case (item_i.idx)
          REG_CTRL_A: begin
            state_o.ctrl_a = item_i.data & CTRL_A_MASK;
            new_code = {state_i.ctrl_b[3], state_o.ctrl_a[1:0]};
            new_wave = wave_of(new_code);
            if (new_wave != wave) begin
              state_o.dir_up = 1'b1;
            end
          end
          REG_CTRL_B: begin
            state_o.ctrl_b = item_i.data[3:0];
            new_code = {item_i.data[3], state_i.ctrl_a[1:0]};
            new_wave = wave_of(new_code);
            if (new_wave != wave) begin
              state_o.dir_up = 1'b1;
            end
            na = actions(state_i.ctrl_a[7:6], 1'b0, new_wave, item_i.data[3]);
            nb = actions(state_i.ctrl_a[5:4], 1'b1, new_wave, item_i.data[3]);
            // force strobes only act in the normal and ctc modes
            if (new_wave == WV_NORMAL || new_wave == WV_CTC) begin
              if (item_i.data[7]) begin
                lvl_a = apply_act(lvl_a, na.on_match, state_o.dir_up);
              end
              if (item_i.data[6]) begin
                lvl_b = apply_act(lvl_b, nb.on_match, state_o.dir_up);
              end
            end
            state_o.pins = {lvl_b, lvl_a};
          end
          REG_COUNT: begin
            state_o.count   = item_i.data;
            state_o.blocked = 1'b1;
          end
          REG_OCR_A: begin
            state_o.ocra_buf = item_i.data;
            if (!dbuf) begin
              state_o.ocra_act = item_i.data;
            end
          end
          REG_OCR_B: begin
            state_o.ocrb_buf = item_i.data;
            if (!dbuf) begin
              state_o.ocrb_act = item_i.data;
            end
          end
          default: ;
        endcase
      end
      REQ_READ: begin
        case (item_i.idx)
          REG_CTRL_A: result_o.read_data = state_i.ctrl_a;
          REG_CTRL_B: result_o.read_data = {4'h0, state_i.ctrl_b};
          REG_COUNT:  result_o.read_data = state_i.count;
          REG_OCR_A:  result_o.read_data = dbuf ? state_i.ocra_buf : state_i.ocra_act;
          REG_OCR_B:  result_o.read_data = dbuf ? state_i.ocrb_buf : state_i.ocrb_act;
          default:    result_o.read_data = BYTE_ZERO;
        endcase
      end
      REQ_TICK: begin
        // sync hold stops the prescaled taps but not the undivided clock
        tick_en = (state_i.gate[1:0] == 2'b00) && tap_hit &&
                  !(state_i.gate[2] && cs != CS_DIV1);
      end
      REQ_EDGE: begin
        tick_en = (state_i.gate[1:0] == 2'b00) &&
                  ((cs == CS_EXT_RISE && item_i.rising) ||
                   (cs == CS_EXT_FALL && !item_i.rising));
      end
      REQ_GATE: begin
        state_o.gate = {item_i.sync, item_i.power, item_i.sleep};
      end
      default: ;
    endcase

    top = sel_value(top_of(code), state_i.ocra_act);
    pa  = actions(state_i.ctrl_a[7:6], 1'b0, wave, state_i.ctrl_b[3]);
    pb  = actions(state_i.ctrl_a[5:4], 1'b1, wave, state_i.ctrl_b[3]);
    upd = upd_of(code);

    if (tick_en && wave != WV_RESERVED) begin
      result_o.ovf = (state_i.count == sel_value(ovf_of(code), state_i.ocra_act));
      if (wave == WV_PC) begin
        if (state_i.dir_up && state_i.count == top) begin
          dir = 1'b0;
        end else if (!state_i.dir_up && state_i.count == BYTE_ZERO) begin
          dir = 1'b1;
        end
      end
      if (!state_i.blocked) begin
        if (state_i.count == state_i.ocra_act) begin
          lvl_a = apply_act(lvl_a, pa.on_match, dir);
          result_o.match_a = 1'b1;
        end
        if (state_i.count == state_i.ocrb_act) begin
          lvl_b = apply_act(lvl_b, pb.on_match, dir);
          result_o.match_b = 1'b1;
        end
      end
      state_o.blocked = 1'b0;
      // phase correct with a compare value at zero or above top
      if (wave == WV_PC) begin
        if (state_i.ocra_act == BYTE_ZERO || state_i.ocra_act > top) begin
          lvl_a = apply_act(lvl_a, pa.on_match, 1'b1);
        end
        if (state_i.ocrb_act == BYTE_ZERO || state_i.ocrb_act > top) begin
          lvl_b = apply_act(lvl_b, pb.on_match, 1'b1);
        end
      end
      if (dir && state_i.count == top) begin
        lvl_a = apply_act(lvl_a, pa.on_top, 1'b1);
        lvl_b = apply_act(lvl_b, pb.on_top, 1'b1);
      end
      if (upd != SEL_NONE && state_i.count == sel_value(upd, state_i.ocra_act)) begin
        state_o.ocra_act = state_i.ocra_buf;
        state_o.ocrb_act = state_i.ocrb_buf;
      end
      if (dir) begin
        state_o.count = (state_i.count == top) ? BYTE_ZERO : state_i.count + 8'd1;
      end else if (state_i.count != BYTE_ZERO) begin
        state_o.count = state_i.count - 8'd1;
      end
      state_o.dir_up = dir;
      state_o.pins   = {lvl_b, lvl_a};
    end

    fin_code = {state_o.ctrl_b[3], state_o.ctrl_a[1:0]};
    fin_wave = wave_of(fin_code);
    fa = actions(state_o.ctrl_a[7:6], 1'b0, fin_wave, state_o.ctrl_b[3]);
    fb = actions(state_o.ctrl_a[5:4], 1'b1, fin_wave, state_o.ctrl_b[3]);

    result_o.count_now   = state_o.count;
    result_o.pin_a_level = state_o.pins[0];
    result_o.pin_b_level = state_o.pins[1];
    result_o.pin_a_owned = (fa.on_match != OC_NONE);
    result_o.pin_b_owned = (fb.on_match != OC_NONE) && (fb.on_match != OC_RESERVED);
    result_o.reserved    = (fin_wave == WV_RESERVED) || (fb.on_match == OC_RESERVED);
  end

endmodule

// ===== rtl/eight_bit_pwm_timer.sv =====
// top level of the 8-bit timer/counter with pwm
//
// one request enters on the slave stream: tuser carries the request kind
// (write, read, prescaler tick, clock pin edge, gating update) and tdata the
// register index, write byte, prescaler taps, edge direction and gating bits
// every request gives exactly one result on the master stream: read byte,
// counter value, both compare pin levels and ownership, the overflow and
// match flags raised by this request, and the reserved-setting flag
// the request is held in an input register; the state update and result are
// worked out by one short combinational pass into the result register, so
// tvalid on the master side rises once the request has passed the input
// register and then been written into the result register
// throughput is one request per cycle while the receiver takes results: both
// registers advance together, set only by the single step pass between them
// when the receiver stalls, the result register holds and the input register
// keeps one more request; s_axis_tready_o then falls until the result is taken
// reset clears both registers and puts the timer in normal mode, counter and
// compare registers at zero, pins low, counting up and the gating released
module eight_bit_pwm_timer
  import ebpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // reg_index[2:0], write_data[10:3], tick_taps[15:11], edge_rising[16],
  // sleep_gate[17], power_gate[18], sync_hold[19], zero fill[23:20]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // read_data[7:0], counter_now[15:8], pin_a_level[16], pin_b_level[17],
  // pin_a_owned[18], pin_b_owned[19], overflow_flag[20], match_a_flag[21],
  // match_b_flag[22], reserved_setting[23]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic    in_valid_q;
  item_t   in_item_q, in_item_d;
  logic    out_valid_q;
  result_t out_res_q, step_res;
  state_t  state_q, step_state;
  logic    advance;

  // unpack the request
  assign in_item_d.req    = s_axis_tuser_i[2:0];
  assign in_item_d.idx    = s_axis_tdata_i[2:0];
  assign in_item_d.data   = s_axis_tdata_i[10:3];
  assign in_item_d.taps   = s_axis_tdata_i[15:11];
  assign in_item_d.rising = s_axis_tdata_i[16];
  assign in_item_d.sleep  = s_axis_tdata_i[17];
  assign in_item_d.power  = s_axis_tdata_i[18];
  assign in_item_d.sync   = s_axis_tdata_i[19];

  // the held request moves on whenever the result register is free or drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  ebpt_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q <= in_item_d;
    end
  end

  // timer state, committed as the request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= step_state;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.reserved, out_res_q.match_b, out_res_q.match_a,
                            out_res_q.ovf, out_res_q.pin_b_owned, out_res_q.pin_a_owned,
                            out_res_q.pin_b_level, out_res_q.pin_a_level,
                            out_res_q.count_now, out_res_q.read_data};

endmodule

// ===== rtl/ebpt_checker.sv =====
// port-level checks of the pwm timer, bound to the top level
module ebpt_checker
  import ebpt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // with no result pending the block always takes a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request refused with empty result register");

  // an accepted request passes the input and result registers and then shows a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> ##1 m_axis_tvalid_o)
    else $error("no result after accepted request");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind eight_bit_pwm_timer ebpt_checker u_ebpt_checker (.*);
